@@ rtl/assert_macros.svh @@
// Assertion macros for the homography inlier counter.
// Each macro takes a label, clock, synchronous reset and the checked terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define HIC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hic: assertion failed");

// Next-cycle implication.
`define HIC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hic: assertion failed");

`else

`define HIC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HIC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/hic_pkg.sv @@
`default_nettype none

package hic_pkg;

  localparam int COORD_FRAC_BITS = 4;
  localparam int COEF_FRAC_BITS  = 24;
  localparam int THRESH_PIXELS   = 5;
  localparam int MAX_MATCHES     = 4096;

  localparam int PT_W     = 16;
  localparam int COEF_W   = 40;
  localparam int NUM_COEF = 8;
  localparam int CIDX_W   = 3;
  localparam int CNT_W    = 13;

  // Projection accumulators: coef * 16-bit point, two terms plus offset.
  localparam int PROJ_W = 58;
  // Reprojection error: 16-bit point * w minus shifted projection.
  localparam int ERR_W  = 76;
  localparam int SQ_W   = 2 * ERR_W;
  localparam int STEP_W = 7;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX =
    CNT_W'((MAX_MATCHES < 8191) ? MAX_MATCHES : 8191);

  // Coefficient register indexes.
  localparam logic [CIDX_W-1:0] H_R0C0 = 3'd0;
  localparam logic [CIDX_W-1:0] H_R0C1 = 3'd1;
  localparam logic [CIDX_W-1:0] H_R0C2 = 3'd2;
  localparam logic [CIDX_W-1:0] H_R1C0 = 3'd3;
  localparam logic [CIDX_W-1:0] H_R1C1 = 3'd4;
  localparam logic [CIDX_W-1:0] H_R1C2 = 3'd5;
  localparam logic [CIDX_W-1:0] H_R2C0 = 3'd6;
  localparam logic [CIDX_W-1:0] H_R2C1 = 3'd7;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_COEF-1:0] coef_bank_t;

  typedef struct packed {
    logic [PT_W-1:0] src_x;
    logic [PT_W-1:0] src_y;
    logic [PT_W-1:0] dst_x;
    logic [PT_W-1:0] dst_y;
    logic            last_match;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/hic_front.sv @@
`default_nettype none

module hic_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire hic_pkg::item_t in_item,
  output logic                q_valid,
  output hic_pkg::item_t      q_item,
  input  wire logic           q_pop
);
  import hic_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  item_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;

  assign in_stall = (fill == FILL_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && q_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/hic_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module hic_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire hic_pkg::coef_bank_t    coefs,
  input  wire logic                   q_valid,
  input  wire hic_pkg::item_t         q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        is_inlier,
  output logic [hic_pkg::CNT_W-1:0]   inlier_count,
  output logic                        end_of_set,
  output logic                        new_best
);
  import hic_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_PROJ = 12'b0000_0000_0010,
    S_OFFS = 12'b0000_0000_0100,
    S_ERR  = 12'b0000_0000_1000,
    S_SUB  = 12'b0000_0001_0000,
    S_SETX = 12'b0000_0010_0000,
    S_SQX  = 12'b0000_0100_0000,
    S_SETY = 12'b0000_1000_0000,
    S_SQY  = 12'b0001_0000_0000,
    S_SETW = 12'b0010_0000_0000,
    S_SQW  = 12'b0100_0000_0000,
    S_CMP  = 12'b1000_0000_0000
  } state_t;

  localparam logic signed [PROJ_W-1:0] W_ONE =
    PROJ_W'(1) << (COEF_FRAC_BITS + COORD_FRAC_BITS);

  state_t                    state;
  item_t                     item;
  logic [STEP_W-1:0]         step;
  logic [PT_W-1:0]           xs;
  logic [PT_W-1:0]           ys;
  logic signed [PROJ_W-1:0]  px;
  logic signed [PROJ_W-1:0]  py;
  logic signed [PROJ_W-1:0]  w;
  logic [PROJ_W-1:0]         mw;
  logic                      wnz;
  logic signed [ERR_W-1:0]   ex;
  logic signed [ERR_W-1:0]   ey;
  logic [ERR_W-1:0]          mag;
  logic [ERR_W-1:0]          msh;
  logic [SQ_W-1:0]           acc;
  logic [SQ_W-1:0]           lhs;
  logic [CNT_W-1:0]          running;
  logic [CNT_W-1:0]          best;

  logic signed [PROJ_W-1:0]  k [NUM_COEF];
  logic signed [ERR_W-1:0]   wext;
  logic [SQ_W-1:0]           acc_next;
  logic                      sq_last;
  logic                      out_free;
  logic                      inlier;
  logic [CNT_W-1:0]          running_next;
  logic                      finish;

  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) begin
      k[i] = PROJ_W'($signed(coefs[i]));
    end
  end

  assign wext     = ERR_W'(w);
  assign acc_next = (acc << 1) + (msh[ERR_W-1] ? SQ_W'(mag) : '0);
  assign sq_last  = (step == STEP_W'(ERR_W - 1));
  assign out_free = !out_valid || !out_stall;
  assign inlier   = wnz && (lhs < acc);
  assign running_next = (inlier && running < COUNT_MAX) ? running + 1'b1 : running;
  assign finish   = (state == S_CMP) && out_free;
  assign q_pop    = (state == S_IDLE) && q_valid;

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_PROJ;
          end
        end
        S_PROJ: begin
          if (step == STEP_W'(PT_W - 1)) begin
            state <= S_OFFS;
          end
        end
        S_OFFS: state <= S_ERR;
        S_ERR: begin
          if (step == STEP_W'(PT_W - 1)) begin
            state <= S_SUB;
          end
        end
        S_SUB:  state <= (w == '0) ? S_CMP : S_SETX;
        S_SETX: state <= S_SQX;
        S_SQX: begin
          if (sq_last) begin
            state <= S_SETY;
          end
        end
        S_SETY: state <= S_SQY;
        S_SQY: begin
          if (sq_last) begin
            state <= S_SETW;
          end
        end
        S_SETW: state <= S_SQW;
        S_SQW: begin
          if (sq_last) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item <= q_item;
        xs   <= q_item.src_x;
        ys   <= q_item.src_y;
        px   <= '0;
        py   <= '0;
        w    <= '0;
        step <= '0;
      end
      S_PROJ: begin
        // MSB-first shift-add over the source point bits
        px   <= (px <<< 1) + (xs[PT_W-1] ? k[H_R0C0] : '0) + (ys[PT_W-1] ? k[H_R0C1] : '0);
        py   <= (py <<< 1) + (xs[PT_W-1] ? k[H_R1C0] : '0) + (ys[PT_W-1] ? k[H_R1C1] : '0);
        w    <= (w <<< 1) + (xs[PT_W-1] ? k[H_R2C0] : '0) + (ys[PT_W-1] ? k[H_R2C1] : '0);
        xs   <= xs << 1;
        ys   <= ys << 1;
        step <= step + 1'b1;
      end
      S_OFFS: begin
        px   <= px + (k[H_R0C2] <<< COORD_FRAC_BITS);
        py   <= py + (k[H_R1C2] <<< COORD_FRAC_BITS);
        w    <= w + W_ONE;
        xs   <= item.dst_x;
        ys   <= item.dst_y;
        ex   <= '0;
        ey   <= '0;
        step <= '0;
      end
      S_ERR: begin
        ex   <= (ex <<< 1) + (xs[PT_W-1] ? wext : '0);
        ey   <= (ey <<< 1) + (ys[PT_W-1] ? wext : '0);
        xs   <= xs << 1;
        ys   <= ys << 1;
        step <= step + 1'b1;
      end
      S_SUB: begin
        ex  <= ex - (ERR_W'(px) <<< COORD_FRAC_BITS);
        ey  <= ey - (ERR_W'(py) <<< COORD_FRAC_BITS);
        mw  <= w[PROJ_W-1] ? PROJ_W'(-w) : PROJ_W'(w);
        wnz <= (w != '0);
      end
      S_SETX: begin
        mag  <= ex[ERR_W-1] ? ERR_W'(-ex) : ERR_W'(ex);
        msh  <= ex[ERR_W-1] ? ERR_W'(-ex) : ERR_W'(ex);
        acc  <= '0;
        step <= '0;
      end
      S_SETY: begin
        lhs  <= acc;
        mag  <= ey[ERR_W-1] ? ERR_W'(-ey) : ERR_W'(ey);
        msh  <= ey[ERR_W-1] ? ERR_W'(-ey) : ERR_W'(ey);
        acc  <= '0;
        step <= '0;
      end
      S_SETW: begin
        // threshold folded into the square: (thresh * |w| * 2^C)^2
        lhs  <= lhs + acc;
        mag  <= (ERR_W'(mw) * ERR_W'(THRESH_PIXELS)) << COORD_FRAC_BITS;
        msh  <= (ERR_W'(mw) * ERR_W'(THRESH_PIXELS)) << COORD_FRAC_BITS;
        acc  <= '0;
        step <= '0;
      end
      S_SQX, S_SQY, S_SQW: begin
        acc  <= acc_next;
        msh  <= msh << 1;
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= '0;
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
        if (item.last_match) begin
          running <= '0;
          if (running_next > best) begin
            best <= running_next;
          end
        end else begin
          running <= running_next;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      is_inlier    <= inlier;
      inlier_count <= running_next;
      end_of_set   <= item.last_match;
      new_best     <= item.last_match && (running_next > best);
    end
  end

  `HIC_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, running <= COUNT_MAX)
  `HIC_ASSERT_IMP(a_best_on_last, clk, rst, out_valid && new_best, end_of_set)
  `HIC_ASSERT_NXT(a_best_hold, clk, rst, !(finish && item.last_match), $stable(best))

endmodule

`default_nettype wire

@@ rtl/homography_inlier_counter_top.sv @@
`default_nettype none
// Channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_stall  | src_x, src_y, dst_x, dst_y, last_match
// output   | out_valid / out_stall| is_inlier, inlier_count, end_of_set, new_best
// config   | cfg_we               | cfg_index (0..7), cfg_data (40 bit)
//
// In the back end each pair runs a projection shift-add over the 16 source
// point bits, an error shift-add over the 16 destination point bits, and
// three 76-bit squarings through one shared shift-add multiplier. A pair
// with zero w skips the squarings. Reset is synchronous and active high; it
// clears the counts, the queue and the sequencer and reloads the identity
// homography. A two-entry queue lets the input side keep feeding while the
// back end works, and the result register holds while out_stall is high
// without blocking the next pair's computation.

module homography_inlier_counter_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input transactions
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [hic_pkg::PT_W-1:0]      src_x,
  input  wire logic [hic_pkg::PT_W-1:0]      src_y,
  input  wire logic [hic_pkg::PT_W-1:0]      dst_x,
  input  wire logic [hic_pkg::PT_W-1:0]      dst_y,
  input  wire logic                          last_match,
  // result transactions
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               is_inlier,
  output logic [hic_pkg::CNT_W-1:0]          inlier_count,
  output logic                               end_of_set,
  output logic                               new_best,
  // coefficient writes
  input  wire logic                          cfg_we,
  input  wire logic [hic_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [hic_pkg::COEF_W-1:0]    cfg_data
);
  import hic_pkg::*;

  coef_bank_t coefs;
  item_t      in_item;
  item_t      q_item;
  logic       q_valid;
  logic       q_pop;

  // Coefficient bank: identity on reset, h22 is implied as 1.0.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coefs[i] <= (CIDX_W'(i) == H_R0C0 || CIDX_W'(i) == H_R1C1) ? COEF_ONE : '0;
      end
    end else if (cfg_we) begin
      coefs[cfg_index] <= cfg_data;
    end
  end

  assign in_item = '{src_x: src_x, src_y: src_y, dst_x: dst_x, dst_y: dst_y,
                     last_match: last_match};

  // Front: accept transactions into the queue.
  hic_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Back: project, score, count and hold the result.
  hic_back u_back (
    .clk          (clk),
    .rst          (rst),
    .coefs        (coefs),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_inlier    (is_inlier),
    .inlier_count (inlier_count),
    .end_of_set   (end_of_set),
    .new_best     (new_best)
  );

endmodule

`default_nettype wire

@@ bench/tb_homography_inlier_counter_top.sv @@
`default_nettype none

module tb_homography_inlier_counter_top;
  import hic_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam logic [CIDX_W-1:0] COEF_IDX [NUM_COEF] =
    '{H_R0C0, H_R0C1, H_R0C2, H_R1C0, H_R1C1, H_R1C2, H_R2C0, H_R2C1};

  // One result of the block, as predicted or as seen on the output port.
  typedef struct {
    logic             inlier;
    logic [CNT_W-1:0] count;
    logic             set_end;
    logic             best;
  } score_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [PT_W-1:0] src_x, src_y, dst_x, dst_y;
  logic last_match;
  logic out_valid;
  logic out_stall;
  logic is_inlier;
  logic [CNT_W-1:0] inlier_count;
  logic end_of_set;
  logic new_best;
  logic cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;

  // Shadow of the homography and of the counters inside the block.
  coef_t            hmat [NUM_COEF];
  logic [CNT_W-1:0] run_inliers;
  logic [CNT_W-1:0] best_inliers;

  score_t pending_scores[$];
  int     mismatches;
  int     hold_cycles;   // receiver hold-off, counted down by the stall process

  homography_inlier_counter_top dut (
    .clk, .rst,
    .in_valid, .in_stall, .src_x, .src_y, .dst_x, .dst_y, .last_match,
    .out_valid, .out_stall, .is_inlier, .inlier_count, .end_of_set, .new_best,
    .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Generous ceiling: random traffic with long stalls.
  initial begin
    #(CLK_PERIOD * 4_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Gap length: mostly none, often short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Project one pair through the shadow homography and advance the counters.
  function automatic score_t score_pair(logic [PT_W-1:0] sx, logic [PT_W-1:0] sy,
                                        logic [PT_W-1:0] dx, logic [PT_W-1:0] dy,
                                        logic last);
    score_t s;
    longint px, py, w;
    logic signed [95:0] ew, ex, ey, ddx, ddy, ppx, ppy;
    logic signed [191:0] err_sq, lim_sq;
    px = longint'($signed(hmat[0])) * sx + longint'($signed(hmat[1])) * sy
       + longint'($signed(hmat[2])) * (longint'(1) <<< COORD_FRAC_BITS);
    py = longint'($signed(hmat[3])) * sx + longint'($signed(hmat[4])) * sy
       + longint'($signed(hmat[5])) * (longint'(1) <<< COORD_FRAC_BITS);
    w  = longint'($signed(hmat[6])) * sx + longint'($signed(hmat[7])) * sy
       + (longint'(1) <<< (COEF_FRAC_BITS + COORD_FRAC_BITS));
    s.inlier = 1'b0;
    if (w != 0) begin
      ew = w;
      ppx = px;
      ppy = py;
      ddx = dx;
      ddy = dy;
      ex = ddx * ew - ppx * (96'sd1 <<< COORD_FRAC_BITS);
      ey = ddy * ew - ppy * (96'sd1 <<< COORD_FRAC_BITS);
      err_sq = ex * ex + ey * ey;
      lim_sq = ew * ew;
      lim_sq = lim_sq * (192'sd1 <<< (2 * COORD_FRAC_BITS)) * THRESH_PIXELS * THRESH_PIXELS;
      s.inlier = (err_sq < lim_sq);
    end
    if (s.inlier && run_inliers < COUNT_MAX) run_inliers = run_inliers + 1'b1;
    s.count = run_inliers;
    s.set_end = last;
    s.best = 1'b0;
    if (last) begin
      if (run_inliers > best_inliers) begin
        s.best = 1'b1;
        best_inliers = run_inliers;
      end
      run_inliers = '0;
    end
    return s;
  endfunction

  // Offer one pair, hold it until taken, record its score, then sometimes idle a while.
  task automatic send_pair(logic [PT_W-1:0] sx, logic [PT_W-1:0] sy,
                           logic [PT_W-1:0] dx, logic [PT_W-1:0] dy, logic last);
    int gap;
    in_valid   <= 1'b1;
    src_x      <= sx;
    src_y      <= sy;
    dst_x      <= dx;
    dst_y      <= dy;
    last_match <= last;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_scores = {pending_scores, score_pair(sx, sy, dx, dy, last)};
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Pause the input until every outstanding result is back, then let the back end settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Present one coefficient write for a cycle; the caller drops the enable.
  task automatic write_coef(int k, coef_t value);
    cfg_we    <= 1'b1;
    cfg_index <= COEF_IDX[k];
    cfg_data  <= value;
    @(posedge clk);
    hmat[k] = value;
  endtask

  task automatic load_homography(coef_t m [NUM_COEF]);
    for (int k = 0; k < NUM_COEF; k++) write_coef(k, m[k]);
    cfg_we <= 1'b0;
  endtask

  // Destination that lands near the true projection, with an offset in Q12.4.
  function automatic logic [PT_W-1:0] near_proj(logic [PT_W-1:0] sx, logic [PT_W-1:0] sy,
                                                int row, int offset);
    longint p, w, v;
    p = longint'($signed(hmat[3*row])) * sx + longint'($signed(hmat[3*row+1])) * sy
      + longint'($signed(hmat[3*row+2])) * 16;
    w = longint'($signed(hmat[6])) * sx + longint'($signed(hmat[7])) * sy
      + (longint'(1) <<< (COEF_FRAC_BITS + COORD_FRAC_BITS));
    v = (w == 0) ? 0 : (p * 16) / w;
    v = v + offset;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return PT_W'(v);
  endfunction

  // Plausible homography: near-unit scale, modest rotation, translation, perspective.
  task automatic load_random_homography();
    coef_t m [NUM_COEF];
    m[0] = COEF_ONE + COEF_W'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    m[1] = COEF_W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    m[2] = COEF_W'(longint'($urandom_range(0, 400)) - 200) <<< COEF_FRAC_BITS;
    m[3] = COEF_W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    m[4] = COEF_ONE + COEF_W'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    m[5] = COEF_W'(longint'($urandom_range(0, 400)) - 200) <<< COEF_FRAC_BITS;
    m[6] = COEF_W'($signed($urandom_range(0, 1 << 11)) - (1 << 10));
    m[7] = COEF_W'($signed($urandom_range(0, 1 << 11)) - (1 << 10));
    load_homography(m);
  endtask

  // Random set of pairs: mostly near matches, some wild points.
  task automatic send_random_set(int len);
    logic [PT_W-1:0] sx, sy, dx, dy;
    for (int i = 0; i < len; i++) begin
      sx = PT_W'($urandom_range(0, 65535));
      sy = PT_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 4) == 0) begin
        dx = PT_W'($urandom_range(0, 65535));
        dy = PT_W'($urandom_range(0, 65535));
      end else begin
        dx = near_proj(sx, sy, 0, $urandom_range(0, 200) - 100);
        dy = near_proj(sx, sy, 1, $urandom_range(0, 200) - 100);
      end
      send_pair(sx, sy, dx, dy, i == len - 1);
    end
  endtask

  // Identity from reset: exact hits, threshold edges and coordinate extremes.
  task automatic test_identity_edges();
    send_pair(16'd1600, 16'd800, 16'd1600, 16'd800, 1'b0);
    send_pair(16'd1600, 16'd800, 16'd1679, 16'd800, 1'b0);   // 4.94 px: inside
    send_pair(16'd1600, 16'd800, 16'd1680, 16'd800, 1'b0);   // exactly 5 px: outside
    send_pair(16'd1600, 16'd800, 16'd1648, 16'd864, 1'b0);   // 3-4-5 diagonal, on the edge
    send_pair(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pair(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1);
    send_pair(16'd5, 16'd5, 16'd6, 16'd5, 1'b1);             // smaller set: no new best
    drain();
  endtask

  // Perspective row that drives w through zero and below.
  task automatic test_zero_w();
    coef_t m [NUM_COEF];
    m = '{COEF_ONE, '0, '0, '0, COEF_ONE, '0, -COEF_ONE, '0};
    load_homography(m);
    send_pair(16'd16, 16'd0, 16'd16, 16'd0, 1'b0);           // w is zero: outlier
    send_pair(16'd32, 16'd40, 16'd0, 16'd0, 1'b0);           // w negative
    send_pair(16'd8, 16'd8, 16'd16, 16'd16, 1'b0);           // w = 0.5: scaled up
    send_pair(16'd16, 16'd0, 16'd0, 16'd0, 1'b1);
    drain();
  endtask

  // Full-scale coefficients in both directions.
  task automatic test_extreme_coefs();
    coef_t m [NUM_COEF];
    for (int k = 0; k < NUM_COEF; k++) m[k] = {1'b0, {(COEF_W-1){1'b1}}};
    load_homography(m);
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pair(16'd1, 16'd0, 16'd0, 16'd0, 1'b0);
    drain();
    for (int k = 0; k < NUM_COEF; k++) m[k] = {1'b1, {(COEF_W-1){1'b0}}};
    load_homography(m);
    send_pair(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0);
    send_pair(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b1);
    drain();
  endtask

  // Random homographies, random set lengths, occasional wild coefficients.
  task automatic test_random_sets(int pairs);
    coef_t m [NUM_COEF];
    int sent, len;
    sent = 0;
    while (sent < pairs) begin
      if ($urandom_range(0, 5) == 0) begin
        for (int k = 0; k < NUM_COEF; k++) m[k] = {$urandom(), 8'($urandom())};
        load_homography(m);
      end else begin
        load_random_homography();
      end
      for (int s = 0; s < 4; s++) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
        send_random_set(len);
        sent += len;
      end
      drain();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering pairs.
  task automatic test_backpressure();
    load_random_homography();
    hold_cycles = 3000;
    send_random_set(12);
    drain();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  // Compare each accepted result with the oldest predicted score.
  always @(posedge clk) begin
    score_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: count %0d", inlier_count);
      end else begin
        want = pending_scores.pop_front();
        if (is_inlier !== want.inlier || inlier_count !== want.count ||
            end_of_set !== want.set_end || new_best !== want.best) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected inlier=%0b count=%0d end=%0b best=%0b, got %0b %0d %0b %0b",
                     want.inlier, want.count, want.set_end, want.best,
                     is_inlier, inlier_count, end_of_set, new_best);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    src_x = '0;
    src_y = '0;
    dst_x = '0;
    dst_y = '0;
    last_match = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    hold_cycles = 0;
    hmat = '{COEF_ONE, '0, '0, '0, COEF_ONE, '0, '0, '0};
    run_inliers = '0;
    best_inliers = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity_edges();
    test_zero_w();
    test_extreme_coefs();
    test_backpressure();
    test_random_sets(420);

    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ homography_inlier_counter_top.f @@
+incdir+rtl
rtl/hic_pkg.sv
rtl/hic_front.sv
rtl/hic_back.sv
rtl/homography_inlier_counter_top.sv
bench/tb_homography_inlier_counter_top.sv
